>>> rtl/bst_pkg.sv
// Shared types and constants for the binary search table.
// Used by bst_ctrl, bst_dp and binary_search_table; no dependencies.
`timescale 1ns / 1ps

package bst_pkg;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned POS_W   = 10;

  // Packed bus widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Opcodes carried on in_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr;     // store one table entry
    logic load;   // start a search: capture key, set bounds
    logic rd;     // read the entry at the midpoint
    logic step;   // narrow the bounds after a mismatch
    logic emit;   // load the result into the output register
  } bst_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active; // range still holds at least one entry
    logic match;  // probed entry equals the key
  } bst_stat_t;

endpackage

>>> rtl/binary_search_table.sv
// Binary search table top level: streaming ports, controller and datapath.
// Depends on bst_pkg, bst_ctrl and bst_dp.
//
// Use: write items (in_tuser = 0) store key_or_entry at entry_index and give
// no result. Search items (in_tuser = 1) run a binary
// search over the first table_size entries (cfg_wr_en/cfg_wr_data, clamped
// to TABLE_DEPTH) and give one result: out_tuser = found, out_tdata holds
// the position (0 when not found).
// A search makes P probes (at most log2(TABLE_DEPTH) + 1, so 11 at the
// default depth). Each probe is one registered memory read on the single
// table read port followed by a compare. The next item is taken in the
// cycle that the result shows up.
// Reset clears the controller and table_size; table entries are undefined
// until written. A stalled receiver holds the result in the output
// register; a following write still completes, and a following search runs
// and then waits for the register to free up.
`timescale 1ns / 1ps

module binary_search_table import bst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data,    // table_size
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,       // [9:0] entry_index, [41:10] key_or_entry
  input  logic                  in_tuser,       // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,      // [9:0] position
  output logic                  out_tuser       // [0] found
);

  bst_cmd_t          cmd;
  bst_stat_t         stat;
  logic              hit;
  logic              found_dp;
  logic [POS_W-1:0]  pos_dp;

  bst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .hit        (hit)
  );

  bst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .entry_index  (in_tdata[INDEX_W-1:0]),
    .key_or_entry (in_tdata[INDEX_W+ENTRY_W-1:INDEX_W]),
    .cmd          (cmd),
    .hit          (hit),
    .stat         (stat),
    .out_found    (found_dp),
    .out_position (pos_dp)
  );

  assign out_tuser = found_dp;
  assign out_tdata = OUT_DATA_W'(pos_dp);

  // A write transfer never raises the result valid
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_WRITE) && !out_tvalid) |=> !out_tvalid)
    else $error("write item produced a result");

  // A miss reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found result with nonzero position");

  // A search transfer makes the block busy on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_SEARCH)) |=> !in_tready)
    else $error("input taken during a search");

endmodule

>>> rtl/bst_dp.sv
// Datapath of the binary search table: table memory, search bounds,
// size register and result registers. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_dp import bst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [SIZE_W-1:0]         cfg_wr_data,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [ENTRY_W-1:0] key_or_entry,
  input  bst_cmd_t                  cmd,
  input  logic                      hit,
  output bst_stat_t                 stat,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = (NW > SIZE_W) ? NW : SIZE_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

  logic [SIZE_W-1:0]         table_size_r;
  logic signed [ENTRY_W-1:0] mem_r [TABLE_DEPTH];
  logic signed [ENTRY_W-1:0] rd_data_r;
  logic signed [ENTRY_W-1:0] key_r;
  logic [NW-1:0]             low_r, low_nxt;
  logic [NW-1:0]             hi_ex_r, hi_ex_nxt;
  logic [AW-1:0]             mid_r;
  logic                      found_r;
  logic [POS_W-1:0]          pos_r;
  logic                      out_found_r;
  logic [POS_W-1:0]          out_pos_r;

  logic [SW-1:0] size_ext;
  logic [SW-1:0] idx_ext;
  logic [NW-1:0] n_used;
  logic [NW:0]   mid_sum;
  logic [AW-1:0] mid;

  // Clamp the configured size to the table depth
  assign size_ext = SW'(table_size_r);
  assign n_used   = (size_ext > DEPTH_S) ? NW'(TABLE_DEPTH) : size_ext[NW-1:0];
  assign idx_ext  = SW'(entry_index);

  // Floor midpoint of low and the inclusive upper bound
  assign mid_sum = {1'b0, low_r} + {1'b0, hi_ex_r} - (NW+1)'(1);
  assign mid     = mid_sum[AW:1];

  assign stat.active = (low_r < hi_ex_r);
  assign stat.match  = (rd_data_r == key_r);

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_wr_en) begin
      table_size_r <= cfg_wr_data;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && (idx_ext < DEPTH_S)) begin
      mem_r[idx_ext[AW-1:0]] <= key_or_entry;
    end
    if (cmd.rd) begin
      rd_data_r <= mem_r[mid];
      mid_r     <= mid;
    end
  end

  // Narrow the bounds
  always_comb begin
    low_nxt   = low_r;
    hi_ex_nxt = hi_ex_r;
    if (cmd.load) begin
      low_nxt   = '0;
      hi_ex_nxt = n_used;
    end else if (cmd.step) begin
      if (key_r < rd_data_r) begin
        hi_ex_nxt = NW'(mid_r);
      end else begin
        low_nxt = NW'(mid_r) + NW'(1);
      end
    end
  end

  // Search registers and result; record a hit in the compare cycle
  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    hi_ex_r <= hi_ex_nxt;
    if (cmd.load) begin
      key_r   <= key_or_entry;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else if (hit) begin
      found_r <= 1'b1;
      pos_r   <= POS_W'(mid_r);
    end
    if (cmd.emit) begin
      out_found_r <= found_r;
      out_pos_r   <= pos_r;
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

>>> rtl/bst_ctrl.sv
// Controller of the binary search table: accepts items, sequences the
// probes and owns the output valid flag. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_ctrl import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_tuser,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  bst_stat_t stat,
  output bst_cmd_t  cmd,
  output logic      hit
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    hit           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (stat.active) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_CMP: begin
        if (stat.match) begin
          hit       = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
